// ===== src/fp32_to_fp16_round_mode_assert.svh =====
// assertion macros for the fp32 to fp16 converter
`ifndef FP32_TO_FP16_ROUND_MODE_ASSERT_SVH
`define FP32_TO_FP16_ROUND_MODE_ASSERT_SVH
`define F2H_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define F2H_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/f2h_pkg.sv =====
// package with types and constants for the fp32 to fp16 converter
`timescale 1ns / 1ps
package f2h_pkg;
    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_UP      = 2'd1,
        RM_DOWN    = 2'd2,
        RM_TRUNC   = 2'd3
    } round_mode_t;

    localparam logic [7:0]  EXP_MAX    = 8'hFF;
    localparam logic [4:0]  HALF_EXP_MAX = 5'h1F;

    typedef struct packed {
        logic [1:0]  round_mode;
        logic [31:0] single_bits;
    } req_t;
endpackage

// ===== src/f2h_convert.sv =====
// combinational fp32 to fp16 conversion with rounding
`timescale 1ns / 1ps
module f2h_convert
    import f2h_pkg::*;
(
    input  req_t        req,
    output logic [15:0] half_bits
);
    logic        neg;
    logic [7:0]  efield;
    logic [22:0] frac;
    logic [4:0]  sh;
    logic [47:0] sig_ext;
    logic [10:0] q;
    logic        rbit;
    logic        sticky;
    logic        inc;
    logic [14:0] mag;
    logic [10:0] qn;
    logic        rn;
    logic        sn;
    logic        incn;
    logic        tiny;
    logic        zero;
    logic        nrm;

    always_comb begin
        neg    = req.single_bits[31];
        efield = req.single_bits[30:23];
        frac   = req.single_bits[22:0];
        tiny   = efield < 8'd113;
        zero   = efield < 8'd89;
        nrm    = !tiny;
        sh     = 5'(8'd113 - efield);
        sig_ext = {1'b1, frac, 24'd0} >> sh;
        q       = sig_ext[47:37];
        rbit    = sig_ext[36];
        sticky  = |sig_ext[35:0];
        case (round_mode_t'(req.round_mode))
            RM_NEAREST: inc = rbit && (sticky || q[0]);
            RM_UP:      inc = !neg && (rbit || sticky);
            RM_DOWN:    inc = neg && (rbit || sticky);
            default:    inc = 1'b0;
        endcase
        qn = {1'b0, frac[22:13]};
        rn = frac[12];
        sn = |frac[11:0];
        case (round_mode_t'(req.round_mode))
            RM_NEAREST: incn = rn && (sn || qn[0]);
            RM_UP:      incn = !neg && (rn || sn);
            RM_DOWN:    incn = neg && (rn || sn);
            default:    incn = 1'b0;
        endcase
        mag = {5'(efield - 8'd112), 10'd0} + {4'd0, qn + {10'd0, incn}};
        if (efield == EXP_MAX) begin
            half_bits = {neg, HALF_EXP_MAX, frac[22:13]};
        end else if (efield > 8'd142) begin
            half_bits = {neg, HALF_EXP_MAX, 10'd0};
        end else if (zero) begin
            half_bits = {neg, 15'd0};
        end else if (tiny && !nrm) begin
            half_bits = {neg, 4'd0, q + {10'd0, inc}};
        end else begin
            half_bits = {neg, mag};
        end
    end
endmodule

// ===== src/fp32_to_fp16_round_mode.sv =====
// top level: registered fp32 to fp16 converter on stream channels
// each request is held in an input register, converted, then held in an output register
// throughput: one request per cycle while the result channel does not stall, set by single-pass conversion logic
// aresetn low clears both valid flags; payload registers hold no reset
`timescale 1ns / 1ps
module fp32_to_fp16_round_mode
    import f2h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // single_bits[31:0], round_mode[33:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // half_bits[15:0]
);
    logic        in_valid_reg;
    logic        in_valid_next;
    req_t        in_req_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_data_reg;
    logic [15:0] conv_half;
    logic        adv;

    f2h_convert u_conv (
        .req       (in_req_reg),
        .half_bits (conv_half)
    );

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_tready && s_tvalid) begin
            in_req_reg <= s_tdata[33:0];
        end
        if (adv && in_valid_reg) begin
            out_data_reg <= conv_half;
        end
    end
endmodule

// ===== src/f2h_checker.sv =====
// port-level checker bound to the converter top level
`timescale 1ns / 1ps
`include "fp32_to_fp16_round_mode_assert.svh"
module f2h_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    `F2H_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `F2H_ASSERT_IMPL(a_rdy, aclk, aresetn, m_tready, s_tready)
    `F2H_ASSERT_NEXT(a_fill, aclk, aresetn, s_tvalid && s_tready && m_tready, ##1 m_tvalid)
endmodule

bind fp32_to_fp16_round_mode f2h_checker u_f2h_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// self-checking stream testbench for the fp32 to fp16 converter with rounding modes
`timescale 1ns / 1ps
module testbench;
    import f2h_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    typedef struct packed {
        round_mode_t mode;
        logic [31:0] bits;
    } conv_req_t;

    conv_req_t   pending_reqs[$];
    logic [15:0] expected_halves[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mode_hits[4];
    int          accepted_count = 0;

    fp32_to_fp16_round_mode dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shift right, then round per mode
    function automatic logic [63:0] shift_round(logic [63:0] sig, int sh, round_mode_t mode,
                                                logic neg);
        logic [63:0] q;
        logic        rbit;
        logic        sticky;
        logic        inc;
        q = sig >> sh;
        rbit = sig[sh - 1];
        sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
        case (mode)
            RM_NEAREST: inc = rbit && (sticky || q[0]);
            RM_UP:      inc = !neg && (rbit || sticky);
            RM_DOWN:    inc = neg && (rbit || sticky);
            default:    inc = 1'b0;
        endcase
        return q + inc;
    endfunction

    function automatic logic [15:0] convert_to_half(logic [31:0] x, round_mode_t mode);
        logic [15:0] sgn;
        logic [22:0] frac;
        int          e;
        int          sh;
        logic [63:0] q;
        logic [15:0] mag;
        sgn = {x[31], 15'd0};
        frac = x[22:0];
        e = int'(x[30:23]) - 127;
        if (x[30:23] == EXP_MAX) begin
            return sgn | 16'h7C00 | {6'd0, frac[22:13]};
        end else if (e > 15) begin
            return sgn | 16'h7C00;
        end else if (e < -14) begin
            sh = -14 - e;
            if (sh > 24) return sgn;
            q = shift_round({40'd0, 1'b1, frac}, sh + 13, mode, x[31]);
            return sgn | {5'd0, q[10:0]};
        end
        q = shift_round({41'd0, frac}, 13, mode, x[31]);
        mag = (16'(e + 15) << 10) + q[15:0];
        return sgn | {1'b0, mag[14:0]};
    endfunction

    function automatic logic [31:0] random_single();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: v[30:23] = 8'($urandom_range(112, 143));
            3:       v[30:23] = 8'($urandom_range(88, 113));
            4:       v[30:23] = EXP_MAX;
            5:       v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_req(logic [31:0] bits, round_mode_t mode);
        conv_req_t r;
        r.bits = bits;
        r.mode = mode;
        pending_reqs.push_back(r);
    endtask

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout at %0t", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_halves.push_back(convert_to_half(s_tdata[31:0],
                                                          round_mode_t'(s_tdata[33:32])));
                mode_hits[s_tdata[33:32]]++;
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, pending_reqs[0].mode, pending_reqs[0].bits};
                    void'(pending_reqs.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_halves.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    error_count++;
                end else begin
                    if (m_tdata !== expected_halves[0]) begin
                        $display("%0t: half_bits expected %h actual %h", $time,
                                 expected_halves[0], m_tdata);
                        error_count++;
                    end
                    void'(expected_halves.pop_front());
                end
            end
            m_tready <= $urandom_range(1, 100) > recv_stall_pct;
        end
    end

    initial begin
        int idle_plan[4][2];
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        idle_plan = '{'{0, 0}, '{56, 0}, '{0, 56}, '{20, 20}};
        // directed: zeros, extremes, ties, overflow, subnormals, nan payloads
        for (int m = 0; m < 4; m++) begin
            add_req(32'h0000_0000, round_mode_t'(m));
            add_req(32'hFFFF_FFFF, round_mode_t'(m));
            add_req(32'h7F80_1000, round_mode_t'(m));
            add_req(32'hC77F_F000, round_mode_t'(m));
            add_req(32'h3880_1000, round_mode_t'(m));
            add_req(32'hB3C0_0001, round_mode_t'(m));
        end
        add_req(32'h477F_E000, RM_NEAREST);
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            repeat (256) add_req(random_single(), round_mode_t'($urandom_range(0, 3)));
            while (pending_reqs.size() > 0 || s_tvalid || expected_halves.size() > 0)
                @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        $display("converted %0d values: nearest %0d, up %0d, down %0d, truncate %0d",
                 accepted_count, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (error_count == 0 && expected_halves.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/f2h_pkg.sv
src/f2h_convert.sv
src/fp32_to_fp16_round_mode.sv
src/f2h_checker.sv
tb/testbench.sv
